@@ hw/rtl/mlpp_pkg.sv @@
// Package with shared types and constants of the MPLS label push/pop rewriter.
`timescale 1ns / 1ps

package mlpp_pkg;

   localparam int HOLD_DEPTH = 6;
   localparam int MAX_OUT    = 7;

   localparam logic [4:0] POS_SAT    = 5'd19;
   localparam logic [4:0] POS_ETH_HI = 5'd12;
   localparam logic [4:0] POS_ETH_LO = 5'd13;
   localparam logic [4:0] POS_MPLS_0 = 5'd14;
   localparam logic [4:0] POS_MPLS_3 = 5'd17;
   localparam logic [4:0] POS_IP     = 5'd18;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [7:0] ETH_MPLS_HI = 8'h88;
   localparam logic [7:0] ETH_MPLS_LO = 8'h47;
   localparam logic [7:0] ETH_IPV4_HI = 8'h08;
   localparam logic [7:0] ETH_IPV4_LO = 8'h00;
   localparam logic [7:0] ETH_IPV6_HI = 8'h86;
   localparam logic [7:0] ETH_IPV6_LO = 8'hdd;
   localparam logic [7:0] VER_MASK    = 8'hf0;
   localparam logic [7:0] VER_IPV4    = 8'h40;
   localparam logic [7:0] VER_IPV6    = 8'h60;

   localparam logic [1:0] CSR_LABEL   = 2'd0;
   localparam logic [1:0] CSR_HOP     = 2'd1;
   localparam logic [1:0] CSR_MIN_LEN = 2'd2;

   typedef struct packed {
      logic [19:0] label_value;
      logic [7:0]  hop_limit;
      logic [13:0] min_frame_length;
   } cfg_type;

   typedef struct packed {
      logic [4:0]                  pos;
      logic                        mode;
      logic                        push_ok;
      logic                        has_label;
      logic [2:0]                  held_cnt;
      logic [HOLD_DEPTH-1:0][7:0]  held;
   } ctx_type;

   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] bytes;
      logic [MAX_OUT-1:0]      unl;
      logic [2:0]              cnt;
      logic                    last;
   } burst_type;

endpackage

@@ hw/rtl/mlpp_step.sv @@
// Per-byte rewrite logic: next frame context and the burst of output bytes.
`timescale 1ns / 1ps

module mlpp_step import mlpp_pkg::*; (
   input  ctx_type     cur,
   input  cfg_type     cfg,
   input  logic        opcode,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   input  logic [13:0] frame_length,
   output ctx_type     nxt,
   output burst_type   burst
);

   logic [7:0] word [4];

   assign word[0] = cfg.label_value[19:12];
   assign word[1] = cfg.label_value[11:4];
   assign word[2] = {cfg.label_value[3:0], 4'h1};
   assign word[3] = cfg.hop_limit;

   always_comb begin
      ctx_type   c;
      burst_type o;
      logic [2:0] n;
      logic       flush;
      logic       pass_b;

      c      = cur;
      o      = '0;
      n      = 3'd0;
      flush  = 1'b0;
      pass_b = 1'b0;

      // The first byte of a frame samples mode and the length check.
      if (cur.pos == 5'd0) begin
         c.mode      = opcode;
         c.push_ok   = (frame_length >= cfg.min_frame_length);
         c.has_label = 1'b0;
         c.held_cnt  = 3'd0;
      end

      if (c.mode == OP_PUSH) begin
         if (c.push_ok && c.pos == POS_ETH_HI) begin
            o.bytes[0] = ETH_MPLS_HI;
            n = 3'd1;
            if (last_byte) begin
               o.bytes[1] = ETH_MPLS_LO;
               for (int i = 0; i < 4; i++) begin
                  o.bytes[i+2] = word[i];
               end
               n = 3'd6;
            end
         end else if (c.push_ok && c.pos == POS_ETH_LO) begin
            o.bytes[0] = ETH_MPLS_LO;
            for (int i = 0; i < 4; i++) begin
               o.bytes[i+1] = word[i];
            end
            n = 3'd5;
         end else begin
            o.bytes[0] = data_byte;
            o.unl[0]   = ~c.push_ok;
            n = 3'd1;
         end
      end else begin
         if (c.pos == POS_ETH_HI) begin
            c.held[0]  = data_byte;
            c.held_cnt = 3'd1;
            flush      = last_byte;
         end else if (c.pos == POS_ETH_LO) begin
            if (c.held_cnt == 3'd1 && c.held[0] == ETH_MPLS_HI &&
                data_byte == ETH_MPLS_LO) begin
               c.has_label = 1'b1;
               c.held[1]   = data_byte;
               c.held_cnt  = 3'd2;
               flush       = last_byte;
            end else begin
               flush  = 1'b1;
               pass_b = 1'b1;
            end
         end else if (c.has_label && c.pos >= POS_MPLS_0 && c.pos <= POS_MPLS_3) begin
            if (c.held_cnt < 3'(HOLD_DEPTH)) begin
               c.held[c.held_cnt] = data_byte;
               c.held_cnt         = c.held_cnt + 3'd1;
            end
            flush = last_byte;
         end else if (c.has_label && c.pos == POS_IP) begin
            if ((data_byte & VER_MASK) == VER_IPV4) begin
               c.held_cnt = 3'd0;
               o.bytes[0] = ETH_IPV4_HI;
               o.bytes[1] = ETH_IPV4_LO;
               n = 3'd2;
            end else if ((data_byte & VER_MASK) == VER_IPV6) begin
               c.held_cnt = 3'd0;
               o.bytes[0] = ETH_IPV6_HI;
               o.bytes[1] = ETH_IPV6_LO;
               n = 3'd2;
            end else begin
               flush = 1'b1;
            end
            c.has_label = 1'b0;
            pass_b      = 1'b1;
         end else begin
            pass_b = 1'b1;
         end

         // A flush always starts the burst, so held bytes land in order from slot zero.
         if (flush) begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
               o.bytes[i] = c.held[i];
            end
            n = c.held_cnt;
            c.held_cnt = 3'd0;
         end
         if (pass_b) begin
            o.bytes[n] = data_byte;
            n = n + 3'd1;
         end
      end

      o.cnt  = n;
      o.last = last_byte;

      if (last_byte) begin
         c.pos       = 5'd0;
         c.has_label = 1'b0;
         c.held_cnt  = 3'd0;
      end else if (c.pos < POS_SAT) begin
         c.pos = c.pos + 5'd1;
      end

      nxt   = c;
      burst = o;
   end

endmodule

@@ hw/rtl/mpls_label_push_pop_core.sv @@
// MPLS label push/pop rewriter for a byte stream of Ethernet frames.
// The burst that an input byte yields is offered on rsp_ from the cycle after the byte is taken.
// Throughput: one input byte per cycle while req_tready is high; an input byte that
// yields more than one output byte holds req_tready low while the burst register drains.
// Reset (synchronous, active high) clears the frame context and the output burst,
// and loads the registers with label 0, TTL 64 and minimum length 64.
`timescale 1ns / 1ps

module mpls_label_push_pop_core import mlpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] data_byte, [21:8] frame_length, [23:22] zero
   input  logic        req_tlast,
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,   // [0] left_unlabelled
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);

   cfg_type    cfg_ff, cfg_in;
   ctx_type    ctx_ff, ctx_in;
   burst_type  burst_ff, burst_in, step_burst;
   logic [2:0] rd_ff, rd_in;
   logic       req_xfer;
   logic       rsp_xfer;

   mlpp_step u_step (
      .cur          (ctx_ff),
      .cfg          (cfg_ff),
      .opcode       (req_tuser[0]),
      .data_byte    (req_tdata[7:0]),
      .last_byte    (req_tlast),
      .frame_length (req_tdata[21:8]),
      .nxt          (ctx_in),
      .burst        (step_burst)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (burst_ff.cnt != 3'd0);
   assign rsp_tdata  = burst_ff.bytes[rd_ff];
   assign rsp_tuser  = burst_ff.unl[rd_ff];
   assign rsp_tlast  = burst_ff.last && (burst_ff.cnt == 3'd1);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // A new byte enters when the burst is empty or its final byte leaves this cycle.
   assign req_tready = (burst_ff.cnt == 3'd0) || (burst_ff.cnt == 3'd1 && rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LABEL:   cfg_in.label_value      = csr_data;
            CSR_HOP:     cfg_in.hop_limit        = csr_data[7:0];
            CSR_MIN_LEN: cfg_in.min_frame_length = csr_data[13:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      burst_in = burst_ff;
      rd_in    = rd_ff;
      if (req_xfer) begin
         burst_in = step_burst;
         rd_in    = 3'd0;
      end else if (rsp_xfer) begin
         burst_in.cnt = burst_ff.cnt - 3'd1;
         rd_in        = rd_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.label_value      <= 20'd0;
         cfg_ff.hop_limit        <= 8'd64;
         cfg_ff.min_frame_length <= 14'd64;
         ctx_ff.pos              <= 5'd0;
         ctx_ff.mode             <= OP_PUSH;
         ctx_ff.push_ok          <= 1'b0;
         ctx_ff.has_label        <= 1'b0;
         ctx_ff.held_cnt         <= 3'd0;
         burst_ff.cnt            <= 3'd0;
         rd_ff                   <= 3'd0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_xfer) begin
            ctx_ff.pos       <= ctx_in.pos;
            ctx_ff.mode      <= ctx_in.mode;
            ctx_ff.push_ok   <= ctx_in.push_ok;
            ctx_ff.has_label <= ctx_in.has_label;
            ctx_ff.held_cnt  <= ctx_in.held_cnt;
         end
         burst_ff.cnt <= burst_in.cnt;
         rd_ff        <= rd_in;
      end

      // Payload registers carry no reset.
      if (req_xfer) begin
         ctx_ff.held <= ctx_in.held;
      end
      burst_ff.bytes <= burst_in.bytes;
      burst_ff.unl   <= burst_in.unl;
      burst_ff.last  <= burst_in.last;
   end

endmodule
